/* src/tnopt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tnopt_pkg;

   // Telnet command bytes
   localparam logic [7:0] TN_IAC  = 8'd255;
   localparam logic [7:0] TN_DONT = 8'd254;
   localparam logic [7:0] TN_DO   = 8'd253;
   localparam logic [7:0] TN_WONT = 8'd252;
   localparam logic [7:0] TN_WILL = 8'd251;
   localparam logic [7:0] TN_SB   = 8'd250;
   localparam logic [7:0] TN_IP   = 8'd244;
   localparam logic [7:0] TN_BRK  = 8'd243;
   localparam logic [7:0] TN_SE   = 8'd240;
   localparam logic [7:0] TN_EOR  = 8'd239;

   // Option codes
   localparam logic [7:0] OPT_BIN  = 8'd0;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;
   localparam logic [7:0] OPT_TERM = 8'd24;
   localparam logic [7:0] OPT_EOR  = 8'd25;

   // Terminal-type SEND sub-command and 3270 start-up bytes
   localparam logic [7:0] TERM_SEND   = 8'd1;
   localparam logic [7:0] START_WRITE = 8'hF5;
   localparam logic [7:0] START_WCC   = 8'hC1;

   // Per-option flag table
   localparam int unsigned OPT_COUNT = 256;
   localparam int unsigned FLAG_W    = 4;
   localparam logic [FLAG_W-1:0] F_WILL = 4'b0001;
   localparam logic [FLAG_W-1:0] F_WONT = 4'b0010;
   localparam logic [FLAG_W-1:0] F_DO   = 4'b0100;
   localparam logic [FLAG_W-1:0] F_DONT = 4'b1000;

   // Result kinds
   localparam logic [1:0] K_TX   = 2'd0;
   localparam logic [1:0] K_CHAN = 2'd1;
   localparam logic [1:0] K_END  = 2'd2;
   localparam logic [1:0] K_ATTN = 2'd3;

   // Job queue depth between front and back
   localparam int unsigned Q_DEPTH = 4;

   typedef enum logic [2:0] {
      M_DATA = 3'd0,
      M_IAC  = 3'd1,
      M_WILL = 3'd2,
      M_WONT = 3'd3,
      M_DO   = 3'd4,
      M_DONT = 3'd5,
      M_SB   = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      OP_CHAN = 3'd0,
      OP_END  = 3'd1,
      OP_SE   = 3'd2,
      OP_WILL = 3'd3,
      OP_WONT = 3'd4,
      OP_DO   = 3'd5,
      OP_DONT = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      SC_NONE = 3'd0,
      SC_ONE  = 3'd1,
      SC_TRI  = 3'd2,
      SC_PAIR = 3'd3,
      SC_TERM = 3'd4,
      SC_BIN  = 3'd5
   } script_type;

   typedef enum logic [1:0] {
      BS_IDLE = 2'd0,
      BS_LOOK = 2'd1,
      BS_EMIT = 2'd2
   } back_state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
      logic       idle;
   } job_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
   } rsp_item_type;

   // One result of a reply script, picked by its position.
   function automatic rsp_item_type script_item(script_type sc, logic [2:0] idx,
                                                logic [1:0] kind, logic [7:0] verb,
                                                logic [7:0] opt);
      rsp_item_type it;
      it.kind  = K_TX;
      it.value = TN_IAC;
      case (sc)
         SC_ONE: begin
            it.kind  = kind;
            it.value = opt;
         end
         SC_TRI: begin
            case (idx)
               3'd0:    it.value = TN_IAC;
               3'd1:    it.value = verb;
               default: it.value = opt;
            endcase
         end
         SC_PAIR: begin
            case (idx)
               3'd0, 3'd3: it.value = TN_IAC;
               3'd1:       it.value = TN_WILL;
               3'd4:       it.value = TN_DO;
               default:    it.value = opt;
            endcase
         end
         SC_TERM: begin
            case (idx)
               3'd0, 3'd4: it.value = TN_IAC;
               3'd1:       it.value = TN_SB;
               3'd2:       it.value = OPT_TERM;
               3'd3:       it.value = TERM_SEND;
               default:    it.value = TN_SE;
            endcase
         end
         SC_BIN: begin
            case (idx)
               3'd0:    it.value = START_WRITE;
               3'd1:    it.value = START_WCC;
               3'd2:    it.value = TN_IAC;
               3'd3:    it.value = TN_EOR;
               default: begin
                  it.kind  = K_ATTN;
                  it.value = 8'd0;
               end
            endcase
         end
         default: begin
            it.kind  = K_TX;
            it.value = TN_IAC;
         end
      endcase
      return it;
   endfunction

endpackage

`default_nettype wire

/* src/tnopt_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tnopt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       read_active;
   logic       command_idle;
   logic       channel_stop;

   modport source (output valid, rx_byte, read_active, command_idle, channel_stop,
                   input ready);
   modport sink   (input valid, rx_byte, read_active, command_idle, channel_stop,
                   output ready);
endinterface

`default_nettype wire

/* src/tnopt_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tnopt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       last;

   modport source (output valid, kind, value, last, input ready);
   modport sink   (input valid, kind, value, last, output ready);
endinterface

`default_nettype wire

/* src/tnopt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tnopt_ram #(
   parameter int unsigned WIDTH = 4,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

/* src/tnopt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tnopt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   tnopt_req_if.sink              req_if,
   input  wire logic              q_full,
   output      logic              q_push,
   output      tnopt_pkg::job_type q_job
);
   import tnopt_pkg::*;

   mode_type   mode_ff;
   mode_type   mode_in;
   logic       accept;
   logic       has_job;
   job_type    job;
   logic [7:0] ch;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign ch           = req_if.rx_byte;

   // Next parser mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         case (mode_ff)
            M_DATA: begin
               if (ch == TN_IAC) begin
                  mode_in = M_IAC;
               end
            end
            M_SB: begin
               if (ch == TN_IAC) begin
                  mode_in = M_IAC;
               end
            end
            M_IAC: begin
               if (ch == TN_WILL) begin
                  mode_in = M_WILL;
               end else if (ch == TN_WONT) begin
                  mode_in = M_WONT;
               end else if (ch == TN_DO) begin
                  mode_in = M_DO;
               end else if (ch == TN_DONT) begin
                  mode_in = M_DONT;
               end else if (ch == TN_SB) begin
                  mode_in = M_SB;
               end else begin
                  mode_in = M_DATA;
               end
            end
            default: mode_in = M_DATA;
         endcase
      end
   end

   // Job for the back end
   always_comb begin
      has_job  = 1'b0;
      job.op   = OP_CHAN;
      job.ch   = ch;
      job.idle = req_if.command_idle;
      case (mode_ff)
         M_DATA: begin
            if (ch != TN_IAC && req_if.read_active) begin
               has_job = 1'b1;
               job.op  = req_if.channel_stop ? OP_END : OP_CHAN;
            end
         end
         M_IAC: begin
            if (ch == TN_IAC) begin
               if (req_if.read_active) begin
                  has_job = 1'b1;
                  job.op  = req_if.channel_stop ? OP_END : OP_CHAN;
               end
            end else if (ch == TN_SE) begin
               has_job = 1'b1;
               job.op  = OP_SE;
            end else if (ch == TN_IP || ch == TN_BRK || ch == TN_EOR) begin
               has_job = req_if.read_active;
               job.op  = OP_END;
            end
         end
         M_WILL: begin
            has_job = 1'b1;
            job.op  = OP_WILL;
         end
         M_WONT: begin
            has_job = 1'b1;
            job.op  = OP_WONT;
         end
         M_DO: begin
            has_job = 1'b1;
            job.op  = OP_DO;
         end
         M_DONT: begin
            has_job = 1'b1;
            job.op  = OP_DONT;
         end
         default: has_job = 1'b0;
      endcase
   end

   assign q_push = accept && has_job;
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_DATA;
      end else begin
         mode_ff <= mode_in;
      end
   end
endmodule

`default_nettype wire

/* src/tnopt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tnopt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tnopt_pkg::job_type push_job,
   input  wire logic               pop,
   output      logic               full,
   output      logic               not_empty,
   output      tnopt_pkg::job_type head_job
);
   import tnopt_pkg::*;

   localparam int unsigned PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

   job_type          slot_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_job  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end
endmodule

`default_nettype wire

/* src/tnopt_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tnopt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire tnopt_pkg::job_type q_job,
   output      logic               q_pop,
   tnopt_rsp_if.source             rsp_if
);
   import tnopt_pkg::*;

   localparam int unsigned ADDR_W = $clog2(OPT_COUNT);

   back_state_type    state_ff;
   back_state_type    state_in;

   job_type           job_ff;
   logic              look_valid_ff;

   // Reply script
   script_type        script_ff;
   logic [2:0]        count_ff;
   logic [2:0]        idx_ff;
   logic [7:0]        verb_ff;
   logic [7:0]        opt_ff;
   logic [1:0]        one_kind_ff;

   // Options whose flags are touched from other options live in registers
   logic [FLAG_W-1:0] bin_ff;
   logic [FLAG_W-1:0] eor_ff;
   logic [OPT_COUNT-1:0] valid_ff;

   logic [FLAG_W-1:0] ram_rdata;
   logic [FLAG_W-1:0] fl;
   logic [FLAG_W-1:0] lk_flags;
   logic [FLAG_W-1:0] lk_bin;
   logic [FLAG_W-1:0] lk_eor;
   logic              lk_own;
   logic              ram_we;
   script_type        lk_script;
   logic [2:0]        lk_count;
   logic [7:0]        lk_verb;
   logic [7:0]        lk_opt;
   logic [1:0]        lk_kind;

   logic              out_free;
   logic              is_last;
   rsp_item_type      item;

   logic              rsp_valid_ff;
   rsp_item_type      rsp_item_ff;
   logic              rsp_last_ff;

   tnopt_ram #(
      .WIDTH (FLAG_W),
      .DEPTH (OPT_COUNT)
   ) u_flags (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (job_ff.ch[ADDR_W-1:0]),
      .wr_data (lk_flags),
      .rd_addr (q_job.ch[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Flag lookup and reply selection for the job in hand
   always_comb begin
      if (job_ff.ch == OPT_BIN) begin
         fl = bin_ff;
      end else if (job_ff.ch == OPT_EOR) begin
         fl = eor_ff;
      end else begin
         fl = look_valid_ff ? ram_rdata : '0;
      end
      lk_flags  = fl;
      lk_own    = 1'b0;
      lk_bin    = bin_ff;
      lk_eor    = eor_ff;
      lk_script = SC_NONE;
      lk_count  = 3'd0;
      lk_verb   = TN_IAC;
      lk_opt    = job_ff.ch;
      lk_kind   = K_TX;
      case (job_ff.op)
         OP_CHAN: begin
            lk_script = SC_ONE;
            lk_count  = 3'd1;
            lk_kind   = K_CHAN;
         end
         OP_END: begin
            lk_script = SC_ONE;
            lk_count  = 3'd1;
            lk_kind   = K_END;
            lk_opt    = 8'd0;
         end
         OP_SE: begin
            lk_eor    = (eor_ff & ~F_WILL) | F_DO;
            lk_script = SC_PAIR;
            lk_count  = 3'd6;
            lk_opt    = OPT_EOR;
         end
         OP_WILL: begin
            if (job_ff.ch == OPT_TERM) begin
               if ((fl & F_WILL) == '0) begin
                  lk_own    = 1'b1;
                  lk_flags  = fl | F_WILL;
                  lk_script = SC_TERM;
                  lk_count  = 3'd6;
               end
            end else if (job_ff.ch == OPT_EOR) begin
               if ((fl & F_WILL) == '0) begin
                  lk_eor    = eor_ff | F_WILL;
                  lk_bin    = (bin_ff & ~F_WILL) | F_DO;
                  lk_script = SC_PAIR;
                  lk_count  = 3'd6;
                  lk_opt    = OPT_BIN;
               end
            end else if (job_ff.ch == OPT_BIN) begin
               if ((fl & F_WILL) == '0) begin
                  lk_bin    = bin_ff | F_WILL;
                  lk_script = SC_BIN;
                  lk_count  = job_ff.idle ? 3'd5 : 3'd4;
               end
            end else if (job_ff.ch == OPT_ECHO || job_ff.ch == OPT_SGA) begin
               if ((fl & F_WILL) == '0) begin
                  lk_own    = 1'b1;
                  lk_flags  = fl | F_WILL;
                  lk_eor    = eor_ff | F_DO;
                  lk_script = SC_TRI;
                  lk_count  = 3'd3;
                  lk_verb   = TN_DO;
                  lk_opt    = OPT_EOR;
               end
            end else if ((fl & F_DONT) == '0) begin
               lk_own    = 1'b1;
               lk_flags  = fl | F_DONT;
               lk_script = SC_TRI;
               lk_count  = 3'd3;
               lk_verb   = TN_DONT;
            end
         end
         OP_DO: begin
            if (job_ff.ch == OPT_TERM) begin
               lk_own = 1'b0;
            end else if (job_ff.ch == OPT_ECHO || job_ff.ch == OPT_SGA) begin
               if ((fl & F_WILL) != '0) begin
                  lk_own   = 1'b1;
                  lk_flags = fl | F_DO;
               end
            end else if (job_ff.ch == OPT_EOR) begin
               lk_eor = eor_ff | F_DO;
            end else if (job_ff.ch == OPT_BIN) begin
               if ((fl & F_DO) == '0) begin
                  lk_bin    = bin_ff | F_DO;
                  lk_script = SC_TRI;
                  lk_count  = 3'd3;
                  lk_verb   = TN_DO;
               end
            end else if ((fl & F_WONT) == '0) begin
               lk_own    = 1'b1;
               lk_flags  = fl | F_WONT;
               lk_script = SC_TRI;
               lk_count  = 3'd3;
               lk_verb   = TN_WONT;
            end
         end
         OP_WONT: begin
            if ((fl & F_WONT) == '0) begin
               lk_own    = 1'b1;
               lk_flags  = fl | F_WONT;
               lk_script = SC_TRI;
               lk_count  = 3'd3;
               lk_verb   = TN_WONT;
            end
         end
         OP_DONT: begin
            if ((fl & F_WILL) != '0) begin
               lk_own    = 1'b1;
               lk_flags  = (fl & ~F_WILL) | F_WONT;
               lk_script = SC_TRI;
               lk_count  = 3'd3;
               lk_verb   = TN_WONT;
            end
         end
         default: lk_own = 1'b0;
      endcase
      // Route the option's own update to its register or to the table
      ram_we = 1'b0;
      if (lk_own) begin
         if (job_ff.ch == OPT_BIN) begin
            lk_bin = lk_flags;
         end else if (job_ff.ch == OPT_EOR) begin
            lk_eor = lk_flags;
         end else begin
            ram_we = (state_ff == BS_LOOK);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign is_last  = (idx_ff == count_ff - 3'd1);
   assign item     = script_item(script_ff, idx_ff, one_kind_ff, verb_ff, opt_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE: begin
            if (q_valid) begin
               state_in = BS_LOOK;
            end
         end
         BS_LOOK: begin
            state_in = (lk_count == 3'd0) ? BS_IDLE : BS_EMIT;
         end
         BS_EMIT: begin
            if (out_free && is_last) begin
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      q_pop = 1'b0;
      case (state_ff)
         BS_IDLE: q_pop = q_valid;
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         bin_ff       <= '0;
         eor_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BS_LOOK) begin
            bin_ff <= lk_bin;
            eor_ff <= lk_eor;
            idx_ff <= '0;
            if (ram_we) begin
               valid_ff[job_ff.ch[ADDR_W-1:0]] <= 1'b1;
            end
         end
         if (state_ff == BS_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= idx_ff + 3'd1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BS_IDLE) begin
         job_ff        <= q_job;
         look_valid_ff <= valid_ff[q_job.ch[ADDR_W-1:0]];
      end
      if (state_ff == BS_LOOK) begin
         script_ff   <= lk_script;
         count_ff    <= lk_count;
         verb_ff     <= lk_verb;
         opt_ff      <= lk_opt;
         one_kind_ff <= lk_kind;
      end
      if (state_ff == BS_EMIT && out_free) begin
         rsp_item_ff <= item;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.kind  = rsp_item_ff.kind;
   assign rsp_if.value = rsp_item_ff.value;
   assign rsp_if.last  = rsp_last_ff;
endmodule

`default_nettype wire

/* src/telnet_option_receive_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                              Transaction
// req_if    in   rx_byte[8] read_active command_idle channel_stop     one received byte
// rsp_if    out  kind[2] value[8] last                                one result
//
// A received byte is taken in the cycle it is offered while the job queue has room.
// The back end pops each queued job, looks up its flags, and then emits its results in
// order as rsp_if takes them; bytes that only move the parser queue no job.
// Synchronous reset puts the parser in the data state and marks every option's flags
// clear; no clearing pass is needed. A stalled rsp_if holds the back end only, and the
// front keeps taking bytes until the four-entry queue fills.
module telnet_option_receive_parser (
   input  wire logic   clock,
   input  wire logic   reset,
   tnopt_req_if.sink   req_if,
   tnopt_rsp_if.source rsp_if
);
   import tnopt_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_valid;
   job_type q_in_job;
   job_type q_head_job;

   // Front: track the telnet parser mode and turn each byte into a job
   tnopt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_in_job)
   );

   // Short queue: decouple classification from reply generation
   tnopt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_in_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_job  (q_head_job)
   );

   // Back: look up option flags, update them, and stream the reply
   tnopt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_head_job),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );
endmodule

`default_nettype wire

/* tb/tb_telnet_option_receive_parser.sv */
`timescale 1ns / 1ps

module tb_telnet_option_receive_parser;
   import tnopt_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int STALL_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int SHOW_LIMIT   = 10;

   // One result transaction as it leaves the block
   typedef struct {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } line_result_type;

   logic clock = 1'b0;
   logic reset;

   tnopt_req_if req_if ();
   tnopt_rsp_if rsp_if ();

   telnet_option_receive_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   // Parser state mirrored in the testbench
   mode_type        tn_mode;
   logic [3:0]      opt_flags [OPT_COUNT];
   line_result_type byte_replies [$];   // results of the byte being parsed
   line_result_type owed_results [$];   // results the block still has to deliver

   int send_idle_pct;
   int recv_idle_pct;
   int rx_bytes_sent;
   int mismatches;
   int cycle_count;
   int stall_asked;

   // ---------------------------------------------------------------------
   // Telnet parser prediction
   // ---------------------------------------------------------------------

   function automatic void add_reply(logic [1:0] kind, logic [7:0] value);
      line_result_type r;
      r.kind  = kind;
      r.value = value;
      r.last  = 1'b0;
      byte_replies.push_back(r);
   endfunction

   // Send IAC <verb> <opt> and remember that this verb went out for the option
   function automatic void answer_option(logic [7:0] verb, logic [7:0] opt);
      add_reply(K_TX, TN_IAC);
      add_reply(K_TX, verb);
      add_reply(K_TX, opt);
      case (verb)
         TN_WILL: opt_flags[opt] |= F_WILL;
         TN_WONT: opt_flags[opt] |= F_WONT;
         TN_DO:   opt_flags[opt] |= F_DO;
         TN_DONT: opt_flags[opt] |= F_DONT;
         default: ;
      endcase
   endfunction

   // Data for the channel: only while a read runs; a refused byte ends the command
   function automatic void pass_to_channel(logic [7:0] ch, logic rd, logic stop);
      if (rd) begin
         if (stop) begin
            add_reply(K_END, 8'd0);
         end else begin
            add_reply(K_CHAN, ch);
         end
      end
   endfunction

   function automatic void handle_will(logic [7:0] ch, logic idle);
      logic [3:0] f;
      f = opt_flags[ch];
      if (ch == OPT_TERM) begin
         if ((f & F_WILL) == 0) begin
            opt_flags[ch] |= F_WILL;
            add_reply(K_TX, TN_IAC);
            add_reply(K_TX, TN_SB);
            add_reply(K_TX, OPT_TERM);
            add_reply(K_TX, TERM_SEND);
            add_reply(K_TX, TN_IAC);
            add_reply(K_TX, TN_SE);
         end
      end else if (ch == OPT_EOR) begin
         if ((f & F_WILL) == 0) begin
            opt_flags[ch] |= F_WILL;
            answer_option(TN_WILL, OPT_BIN);
            opt_flags[OPT_BIN] &= ~F_WILL;
            answer_option(TN_DO, OPT_BIN);
         end
      end else if (ch == OPT_BIN) begin
         if ((f & F_WILL) == 0) begin
            opt_flags[ch] |= F_WILL;
            add_reply(K_TX, START_WRITE);
            add_reply(K_TX, START_WCC);
            add_reply(K_TX, TN_IAC);
            add_reply(K_TX, TN_EOR);
            if (idle) begin
               add_reply(K_ATTN, 8'd0);
            end
         end
      end else if (ch == OPT_ECHO || ch == OPT_SGA) begin
         if ((f & F_WILL) == 0) begin
            opt_flags[ch] |= F_WILL;
            answer_option(TN_DO, OPT_EOR);
         end
      end else if ((f & F_DONT) == 0) begin
         answer_option(TN_DONT, ch);
      end
   endfunction

   function automatic void handle_do(logic [7:0] ch);
      logic [3:0] f;
      f = opt_flags[ch];
      if (ch == OPT_TERM) begin
         // terminal type needs no answer
      end else if (ch == OPT_ECHO || ch == OPT_SGA) begin
         if ((f & F_WILL) != 0) begin
            opt_flags[ch] |= F_DO;
         end
      end else if (ch == OPT_EOR) begin
         opt_flags[ch] |= F_DO;
      end else if (ch == OPT_BIN) begin
         if ((f & F_DO) == 0) begin
            answer_option(TN_DO, ch);
         end
      end else if ((f & F_WONT) == 0) begin
         answer_option(TN_WONT, ch);
      end
   endfunction

   // Advance the parser by one received byte and queue the results it owes
   function automatic void parse_rx_byte(logic [7:0] ch, logic rd, logic idle, logic stop);
      byte_replies.delete();
      case (tn_mode)
         M_DATA: begin
            if (ch == TN_IAC) begin
               tn_mode = M_IAC;
            end else begin
               pass_to_channel(ch, rd, stop);
            end
         end
         M_SB: begin
            // drop the subnegotiation body until the next IAC
            if (ch == TN_IAC) begin
               tn_mode = M_IAC;
            end
         end
         M_IAC: begin
            tn_mode = M_DATA;
            case (ch)
               TN_WILL: tn_mode = M_WILL;
               TN_WONT: tn_mode = M_WONT;
               TN_DO:   tn_mode = M_DO;
               TN_DONT: tn_mode = M_DONT;
               TN_SB:   tn_mode = M_SB;
               TN_IAC:  pass_to_channel(ch, rd, stop);
               TN_SE: begin
                  answer_option(TN_WILL, OPT_EOR);
                  opt_flags[OPT_EOR] &= ~F_WILL;
                  answer_option(TN_DO, OPT_EOR);
               end
               TN_IP, TN_BRK, TN_EOR: begin
                  if (rd) begin
                     add_reply(K_END, 8'd0);
                  end
               end
               default: ;   // unknown command: drop it
            endcase
         end
         M_WILL: begin
            handle_will(ch, idle);
            tn_mode = M_DATA;
         end
         M_WONT: begin
            if ((opt_flags[ch] & F_WONT) == 0) begin
               answer_option(TN_WONT, ch);
            end
            tn_mode = M_DATA;
         end
         M_DO: begin
            handle_do(ch);
            tn_mode = M_DATA;
         end
         M_DONT: begin
            if ((opt_flags[ch] & F_WILL) != 0) begin
               opt_flags[ch] &= ~F_WILL;
               answer_option(TN_WONT, ch);
            end
            tn_mode = M_DATA;
         end
         default: tn_mode = M_DATA;
      endcase
      foreach (byte_replies[i]) begin
         byte_replies[i].last = (i == byte_replies.size() - 1);
         owed_results.push_back(byte_replies[i]);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result side: backpressure and checking
   // ---------------------------------------------------------------------

   // Drive ready at the falling edge; hold it low for a long stretch on request.
   initial begin
      int stall_seen;
      int stall_left;
      stall_seen = 0;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_seen != stall_asked) begin
            stall_seen = stall_asked;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compare each accepted result transaction against the oldest owed one.
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
               $display("unexpected result: kind=%0d value=%02h last=%0b",
                        rsp_if.kind, rsp_if.value, rsp_if.last);
            end
         end else begin
            want = owed_results.pop_front();
            if (rsp_if.kind !== want.kind || rsp_if.value !== want.value ||
                rsp_if.last !== want.last) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT) begin
                  $display("result mismatch: expected kind=%0d value=%02h last=%0b,",
                           want.kind, want.value, want.last,
                           " got kind=%0d value=%02h last=%0b",
                           rsp_if.kind, rsp_if.value, rsp_if.last);
               end
            end
         end
      end
   end

   // Bound the run; a hang lands here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Byte side: one received byte per transaction
   // ---------------------------------------------------------------------

   // Offer one byte at the falling edge, hold it until accepted, then predict.
   task automatic send_byte(logic [7:0] ch, logic rd, logic idle, logic stop);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.rx_byte      <= ch;
      req_if.read_active  <= rd;
      req_if.command_idle <= idle;
      req_if.channel_stop <= stop;
      do @(posedge clock); while (!req_if.ready);
      parse_rx_byte(ch, rd, idle, stop);
      rx_bytes_sent++;
   endtask

   // Same, with the side flags drawn at random; a read is active most of the time
   task automatic send_any(logic [7:0] ch);
      send_byte(ch, $urandom_range(3) != 0, 1'($urandom_range(1)), $urandom_range(4) == 0);
   endtask

   function automatic logic [7:0] pick_option();
      case ($urandom_range(7))
         0:       return OPT_BIN;
         1:       return OPT_ECHO;
         2:       return OPT_SGA;
         3:       return OPT_TERM;
         4:       return OPT_EOR;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_verb();
      case ($urandom_range(3))
         0:       return TN_WILL;
         1:       return TN_WONT;
         2:       return TN_DO;
         default: return TN_DONT;
      endcase
   endfunction

   task automatic wait_drained();
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Plain data: to the channel, refused by the channel, and with no read running
   task automatic test_data_bytes();
      send_byte(8'h00, 1'b1, 1'b0, 1'b0);
      send_byte(8'hFE, 1'b1, 1'b0, 1'b1);
      send_byte(8'h41, 1'b0, 1'b1, 1'b1);
   endtask

   // Doubled IAC, end of record, and an unknown command after IAC
   task automatic test_escapes();
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_EOR, 1'b1, 1'b0, 1'b0);
      send_byte(TN_IAC, 1'b0, 1'b0, 1'b0);
      send_byte(8'h41, 1'b1, 1'b0, 1'b0);
   endtask

   // Binary start-up with attention, then revoke it, refuse and decline options
   task automatic test_negotiation();
      send_byte(TN_IAC, 1'b0, 1'b1, 1'b0);
      send_byte(TN_WILL, 1'b0, 1'b1, 1'b0);
      send_byte(OPT_BIN, 1'b0, 1'b1, 1'b0);
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_DONT, 1'b1, 1'b0, 1'b0);
      send_byte(OPT_BIN, 1'b1, 1'b0, 1'b0);
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_WONT, 1'b1, 1'b0, 1'b0);
      send_byte(8'h80, 1'b1, 1'b0, 1'b0);
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_DO, 1'b1, 1'b0, 1'b0);
      send_byte(8'h7F, 1'b1, 1'b0, 1'b0);
   endtask

   // Terminal-type subnegotiation: body dropped, IAC SE answers the EOR pair
   task automatic test_subnegotiation();
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_SB, 1'b1, 1'b0, 1'b0);
      send_byte(OPT_TERM, 1'b1, 1'b0, 1'b0);
      send_byte(8'h01, 1'b1, 1'b0, 1'b0);
      send_byte(TN_IAC, 1'b1, 1'b0, 1'b0);
      send_byte(TN_SE, 1'b1, 1'b0, 1'b0);
   endtask

   // Mostly well-formed telnet sequences with random content, some noise
   task automatic test_random_traffic(int byte_count);
      int goal;
      int pick;
      int body_len;
      goal = rx_bytes_sent + byte_count;
      while (rx_bytes_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            send_any(8'($urandom_range(254)));
         end else if (pick < 32) begin
            send_any(TN_IAC);
            send_any(TN_IAC);
         end else if (pick < 40) begin
            send_any(TN_IAC);
            case ($urandom_range(2))
               0:       send_any(TN_EOR);
               1:       send_any(TN_IP);
               default: send_any(TN_BRK);
            endcase
         end else if (pick < 75) begin
            send_any(TN_IAC);
            send_any(pick_verb());
            send_any(pick_option());
         end else if (pick < 82) begin
            send_any(TN_IAC);
            send_any(TN_SB);
            body_len = $urandom_range(3);
            repeat (body_len) send_any(8'($urandom_range(254)));
            send_any(TN_IAC);
            send_any(TN_SE);
         end else if (pick < 90) begin
            send_any(8'($urandom_range(255)));
         end else begin
            // broken sequence: IAC followed by anything
            send_any(TN_IAC);
            send_any(8'($urandom_range(255)));
         end
      end
   endtask

   // Hold the result side off while bytes keep coming, so the job queue fills
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_asked++;
      repeat (24) send_byte(8'($urandom_range(254)), 1'b1, 1'b0, 1'b0);
   endtask

   initial begin
      mismatches    = 0;
      rx_bytes_sent = 0;
      stall_asked   = 0;
      send_idle_pct = 14;
      recv_idle_pct = 52;
      tn_mode       = M_DATA;
      foreach (opt_flags[i]) opt_flags[i] = 4'd0;

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.rx_byte      = 8'd0;
      req_if.read_active  = 1'b0;
      req_if.command_idle = 1'b0;
      req_if.channel_stop = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_data_bytes();
      test_escapes();
      test_negotiation();
      test_subnegotiation();
      test_random_traffic(70);

      // swap who idles
      send_idle_pct = 52;
      recv_idle_pct = 14;
      test_random_traffic(70);

      // full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(30);
      test_backpressure();

      @(negedge clock);
      req_if.valid <= 1'b0;
      wait_drained();
      mismatches += owed_results.size();

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* files.f */
src/tnopt_pkg.sv
src/tnopt_req_if.sv
src/tnopt_rsp_if.sv
src/tnopt_ram.sv
src/tnopt_front.sv
src/tnopt_queue.sv
src/tnopt_back.sv
src/telnet_option_receive_parser.sv
tb/tb_telnet_option_receive_parser.sv
